FILE: rtl/b2r_pkg.sv
// Shared types, constants and digit helpers for the binary to Roman numeral converter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package b2r_pkg;

  localparam int unsigned ValueW      = 14;
  localparam int unsigned SymbolW     = 8;
  localparam int unsigned DefMaxValue = 3000;
  localparam int unsigned MaxResults  = 14;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StRange = 2'd1,
    StZero  = 2'd2
  } b2r_status_e;

  localparam logic [SymbolW-1:0] CharI = 8'h49;
  localparam logic [SymbolW-1:0] CharV = 8'h56;
  localparam logic [SymbolW-1:0] CharX = 8'h58;
  localparam logic [SymbolW-1:0] CharL = 8'h4C;
  localparam logic [SymbolW-1:0] CharC = 8'h43;
  localparam logic [SymbolW-1:0] CharD = 8'h44;
  localparam logic [SymbolW-1:0] CharM = 8'h4D;
  localparam logic [SymbolW-1:0] CharNone = 8'h00;

  // One classified number, split into its decimal digits.
  typedef struct packed {
    b2r_status_e status;
    logic [1:0]  thou;
    logic [3:0]  hund;
    logic [3:0]  tens;
    logic [3:0]  unit;
  } b2r_item_t;

  // Number of numeral characters that one decimal digit needs.
  function automatic logic [2:0] digit_len(input logic [3:0] dig);
    logic [2:0] len;
    unique case (dig)
      4'd0:    len = 3'd0;
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd3;
      4'd8:    len = 3'd4;
      4'd9:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Character at position step of a digit, given the one, five and ten symbols of its place.
  function automatic logic [SymbolW-1:0] digit_char(
    input logic [3:0]         dig,
    input logic [1:0]         step,
    input logic [SymbolW-1:0] one,
    input logic [SymbolW-1:0] five,
    input logic [SymbolW-1:0] ten
  );
    logic [SymbolW-1:0] ch;
    priority if (dig == 4'd9) begin
      ch = (step == 2'd0) ? one : ten;
    end else if (dig == 4'd4) begin
      ch = (step == 2'd0) ? one : five;
    end else if (dig >= 4'd5) begin
      ch = (step == 2'd0) ? five : one;
    end else begin
      ch = one;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/b2r_front.sv
// Front end: accepts numbers, classifies them and splits them into decimal digits.
// Depends on b2r_pkg; feeds the item queue.
`default_nettype none

module b2r_front
  import b2r_pkg::*;
#(
  parameter int unsigned MaxValue = DefMaxValue
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   full_o,
  input  wire logic              q_full_i,
  output logic                   q_wr_o,
  output b2r_item_t              q_item_o
);

  logic        s_valid_q, s_valid_d;
  b2r_status_e s_status_q, s_status_d;
  logic [1:0]  s_thou_q, s_thou_d;
  logic [9:0]  s_rem_q, s_rem_d;

  logic        accept;
  logic [11:0] v12;
  logic [11:0] rem12;
  logic [15:0] hund_prod;
  logic [3:0]  hund;
  logic [9:0]  rem_h;
  logic [13:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  rem_t;
  logic [6:0]  unit_w;

  assign q_wr_o = s_valid_q && !q_full_i;
  assign full_o = s_valid_q && q_full_i;
  assign accept = push_i && !full_o;

  // First stage: classification and the thousands digit by comparison.
  always_comb begin
    v12 = value_i[11:0];
    priority if (value_i == '0) begin
      s_status_d = StZero;
    end else if (value_i > ValueW'(MaxValue)) begin
      s_status_d = StRange;
    end else begin
      s_status_d = StOk;
    end
    priority if (v12 >= 12'd3000) begin
      s_thou_d = 2'd3;
    end else if (v12 >= 12'd2000) begin
      s_thou_d = 2'd2;
    end else if (v12 >= 12'd1000) begin
      s_thou_d = 2'd1;
    end else begin
      s_thou_d = 2'd0;
    end
    rem12   = v12 - 12'(12'(s_thou_d) * 12'd1000);
    s_rem_d = rem12[9:0];
  end

  assign s_valid_d = accept ? 1'b1 : (q_wr_o ? 1'b0 : s_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q  <= 1'b0;
      s_status_q <= StOk;
      s_thou_q   <= '0;
      s_rem_q    <= '0;
    end else begin
      s_valid_q <= s_valid_d;
      if (accept) begin
        s_status_q <= s_status_d;
        s_thou_q   <= s_thou_d;
        s_rem_q    <= s_rem_d;
      end
    end
  end

  // Second stage: hundreds and tens by reciprocal multiplication, exact for the
  // remainder ranges below one thousand and one hundred.
  always_comb begin
    hund_prod = 16'(s_rem_q) * 16'd41;
    hund      = hund_prod[15:12];
    rem_h     = s_rem_q - 10'(10'(hund) * 10'd100);
    rem_t     = rem_h[6:0];
    tens_prod = 14'(rem_t) * 14'd103;
    tens      = tens_prod[13:10];
    unit_w    = rem_t - 7'(7'(tens) * 7'd10);
  end

  assign q_item_o = '{
    status: s_status_q,
    thou:   s_thou_q,
    hund:   hund,
    tens:   tens,
    unit:   unit_w[3:0]
  };

endmodule

`default_nettype wire

FILE: rtl/b2r_fifo.sv
// Short queue of classified numbers between the front end and the character sequencer.
// Depends on b2r_pkg for the item type.
`default_nettype none

module b2r_fifo
  import b2r_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_i,
  input  wire b2r_item_t wr_item_i,
  output logic           full_o,
  input  wire logic      rd_i,
  output logic           nonempty_o,
  output b2r_item_t      rd_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b2r_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o     = (count_q == CntW'(Depth));
  assign nonempty_o = (count_q != '0);
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && nonempty_o;
  assign rd_item_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_rd) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b2r_back.sv
// Character sequencer: walks the digits of one queued number and presents one
// numeral character per beat. Depends on b2r_pkg.
`default_nettype none

module b2r_back
  import b2r_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                item_valid_i,
  input  wire b2r_item_t           item_i,
  output logic                     item_rd_o,
  output logic                     empty_o,
  input  wire logic                pop_i,
  output logic [SymbolW-1:0]       symbol_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  logic       busy_q, busy_d;
  b2r_item_t  cur_q, cur_d;
  logic [1:0] place_q, place_d;
  logic [1:0] step_q, step_d;
  logic [3:0] cnt_q, cnt_d;

  logic [2:0] cur_len [4];
  logic [2:0] new_len [4];
  logic [3:0] cur_nz, new_nz, above;
  logic [2:0] len_here;
  logic       digit_end, more, is_last;

  function automatic logic [1:0] lowest_from(input logic [3:0] nz, input logic [2:0] from);
    logic [1:0] r;
    r = '0;
    for (int p = 3; p >= 0; p--) begin
      if (nz[p] && (3'(p) >= from)) begin
        r = 2'(p);
      end
    end
    return r;
  endfunction

  always_comb begin
    cur_len[0] = {1'b0, cur_q.thou};
    cur_len[1] = digit_len(cur_q.hund);
    cur_len[2] = digit_len(cur_q.tens);
    cur_len[3] = digit_len(cur_q.unit);
    new_len[0] = {1'b0, item_i.thou};
    new_len[1] = digit_len(item_i.hund);
    new_len[2] = digit_len(item_i.tens);
    new_len[3] = digit_len(item_i.unit);
    for (int p = 0; p < 4; p++) begin
      cur_nz[p] = (cur_len[p] != '0);
      new_nz[p] = (new_len[p] != '0);
      above[p]  = (3'(p) > {1'b0, place_q});
    end
  end

  assign len_here  = cur_len[place_q];
  assign digit_end = ({1'b0, step_q} == (len_here - 3'd1));
  assign more      = |(cur_nz & above);
  assign is_last   = (cur_q.status != StOk) || (cnt_q == 4'(MaxResults - 1)) ||
                     (digit_end && !more);

  always_comb begin
    unique case (place_q)
      2'd0:    symbol_o = CharM;
      2'd1:    symbol_o = digit_char(cur_q.hund, step_q, CharC, CharD, CharM);
      2'd2:    symbol_o = digit_char(cur_q.tens, step_q, CharX, CharL, CharC);
      default: symbol_o = digit_char(cur_q.unit, step_q, CharI, CharV, CharX);
    endcase
    if (cur_q.status != StOk) begin
      symbol_o = CharNone;
    end
  end

  assign empty_o  = !busy_q;
  assign status_o = cur_q.status;
  assign last_o   = is_last;

  always_comb begin
    busy_d    = busy_q;
    cur_d     = cur_q;
    place_d   = place_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    item_rd_o = 1'b0;
    if (!busy_q || (pop_i && is_last)) begin
      busy_d = item_valid_i;
      if (item_valid_i) begin
        item_rd_o = 1'b1;
        cur_d     = item_i;
        place_d   = lowest_from(new_nz, 3'd0);
        step_d    = '0;
        cnt_d     = '0;
      end
    end else if (pop_i) begin
      cnt_d = cnt_q + 1'b1;
      if (digit_end) begin
        place_d = lowest_from(cur_nz, 3'(place_q) + 3'd1);
        step_d  = '0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cur_q   <= '{status: StOk, default: '0};
      place_q <= '0;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      cur_q   <= cur_d;
      place_q <= place_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/binary_to_roman_numeral.sv
// Top level of the binary to Roman numeral converter.
// Depends on b2r_pkg, b2r_front, b2r_fifo and b2r_back.
//
// Usage. A 14-bit number is written with push and value_i; it is taken at a
// clock edge where push is high and full is low. Its Roman numeral comes out
// as one ASCII character per beat on symbol_o, oldest first, valid while empty
// is low and taken when pop is high. last_o marks the final beat of a number.
// Zero gives a single beat with status zero, and any number above MaxValue a
// single beat with status out of range; both carry a zero symbol. At most
// fourteen characters are given for one number.
// Path. A taken number is held in the front end's register until the item
// queue has room; the digit stage then writes it into the queue, and the
// character sequencer loads it from there once it is free. The sequencer
// gives one character per cycle while pop is high, and loads the next number
// in the same cycle its last beat is taken. A numeral has 1 to 14 characters.
// Stalls. While pop is low the current beat holds; the front end and the
// two-entry queue keep taking numbers until they fill, then full rises.
// Reset clears the queue and the sequencer; no beat is pending after it.
`default_nettype none

module binary_to_roman_numeral
  import b2r_pkg::*;
#(
  parameter int unsigned MaxValue = DefMaxValue
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  input  wire logic [ValueW-1:0]   value_i,
  output logic                     full,
  output logic                     empty,
  input  wire logic                pop,
  output logic [SymbolW-1:0]       symbol_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  logic      q_wr, q_full, q_nonempty, q_rd;
  b2r_item_t q_wr_item, q_rd_item;
  logic      full_o, empty_o;

  assign full  = full_o;
  assign empty = empty_o;

  b2r_front #(
    .MaxValue (MaxValue)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .value_i  (value_i),
    .full_o   (full_o),
    .q_full_i (q_full),
    .q_wr_o   (q_wr),
    .q_item_o (q_wr_item)
  );

  b2r_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .wr_item_i  (q_wr_item),
    .full_o     (q_full),
    .rd_i       (q_rd),
    .nonempty_o (q_nonempty),
    .rd_item_o  (q_rd_item)
  );

  b2r_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_nonempty),
    .item_i       (q_rd_item),
    .item_rd_o    (q_rd),
    .empty_o      (empty_o),
    .pop_i        (pop),
    .symbol_o     (symbol_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

FILE: verif/binary_to_roman_numeral_test.sv
// Self-checking testbench for the binary to Roman numeral converter.
// Depends on b2r_pkg and binary_to_roman_numeral, and through it on the rest of the block.
`timescale 1ns / 1ps

module binary_to_roman_numeral_test;
  import b2r_pkg::*;

  // The block is built with its default largest convertible value.
  localparam int unsigned MaxValue = DefMaxValue;

  // One expected output beat: a numeral character, or a lone status beat.
  typedef struct packed {
    logic [SymbolW-1:0] symbol;
    b2r_status_e        status;
    logic               last;
  } numeral_beat_t;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic [ValueW-1:0]  value_i;
  logic               full;
  logic               empty;
  logic               pop;
  logic [SymbolW-1:0] symbol_o;
  logic [1:0]         status_o;
  logic               last_o;

  // Beats that the block still owes, oldest first.
  numeral_beat_t pending_beats[$];
  int unsigned   error_count;
  // When set, neither the number sender nor the beat receiver stalls.
  logic          idle_off;

  binary_to_roman_numeral i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .value_i  (value_i),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .symbol_o (symbol_o),
    .status_o (status_o),
    .last_o   (last_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Appends the characters of one decimal digit, given the one, five and ten
  // symbols of its place. Nine and four use the subtractive pairs.
  function automatic void append_digit(ref logic [SymbolW-1:0] chars[$],
                                       input int unsigned dig,
                                       input logic [SymbolW-1:0] one,
                                       input logic [SymbolW-1:0] five,
                                       input logic [SymbolW-1:0] ten);
    int unsigned rest;
    rest = dig;
    if (dig == 9) begin
      chars.push_back(one);
      chars.push_back(ten);
    end else if (dig == 4) begin
      chars.push_back(one);
      chars.push_back(five);
    end else begin
      if (rest >= 5) begin
        chars.push_back(five);
        rest = rest - 5;
      end
      for (int unsigned k = 0; k < rest && k < 4; k++) begin
        chars.push_back(one);
      end
    end
  endfunction

  // Works out every beat that one accepted number must produce and queues them.
  function automatic void predict_numeral(input logic [ValueW-1:0] value);
    logic [SymbolW-1:0] chars[$];
    numeral_beat_t      beat;
    int unsigned        v;
    int unsigned        count;
    v = 32'(value);
    if (v == 0) begin
      // Zero has no numeral; a single status beat stands in for it.
      beat = '{symbol: CharNone, status: StZero, last: 1'b1};
      pending_beats.push_back(beat);
    end else if (v > MaxValue) begin
      beat = '{symbol: CharNone, status: StRange, last: 1'b1};
      pending_beats.push_back(beat);
    end else begin
      for (int unsigned k = 0; k < v / 1000 && k < 4; k++) begin
        chars.push_back(CharM);
      end
      append_digit(chars, (v / 100) % 10, CharC, CharD, CharM);
      append_digit(chars, (v / 10) % 10, CharX, CharL, CharC);
      append_digit(chars, v % 10, CharI, CharV, CharX);
      // An overlong numeral is cut after the fourteenth character.
      count = (chars.size() > MaxResults) ? MaxResults : chars.size();
      for (int unsigned k = 0; k < count; k++) begin
        beat = '{symbol: chars[k], status: StOk, last: (k == count - 1)};
        pending_beats.push_back(beat);
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Sends one number, with a random idle burst in front of it unless idling is
  // off. push stays high after the beat so the next number can follow at once.
  task automatic send_value(input logic [ValueW-1:0] value);
    int unsigned gap;
    if (!idle_off && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    value_i <= value;
    do @(posedge clk_i); while (full);
    predict_numeral(value);
  endtask

  // Lowers push and waits until every owed beat has been taken, then lets the
  // pipeline settle.
  task automatic wait_for_drain();
    push <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // The receiver takes beats, stalling in random bursts unless idling is off.
  initial begin : beat_receiver
    int unsigned stall;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!idle_off && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 14);
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Every beat taken from the block is compared with the oldest expectation.
  always @(posedge clk_i) begin
    numeral_beat_t beat;
    if (rst_ni && pop && !empty) begin
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat symbol=%h status=%0d last=%b",
                                  symbol_o, status_o, last_o));
      end else begin
        beat = pending_beats.pop_front();
        if (symbol_o !== beat.symbol) begin
          report_mismatch($sformatf("symbol %h, expected %h", symbol_o, beat.symbol));
        end
        if (status_o !== beat.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", status_o, beat.status));
        end
        if (last_o !== beat.last) begin
          report_mismatch($sformatf("last %b, expected %b", last_o, beat.last));
        end
      end
    end
  end

  // Extremes of the input, zero, the range boundary and the longest numeral.
  task automatic test_boundaries();
    send_value(14'd0);
    send_value(14'd1);
    send_value(ValueW'(MaxValue));
    send_value(ValueW'(MaxValue + 1));
    send_value(14'h3FFF);
    send_value(14'd3999);
    send_value(14'd4000);
    send_value(14'd2888);
    wait_for_drain();
  endtask

  // The subtractive pairs and the five symbols in each decimal place.
  task automatic test_digit_patterns();
    send_value(14'd4);
    send_value(14'd9);
    send_value(14'd5);
    send_value(14'd8);
    send_value(14'd40);
    send_value(14'd90);
    send_value(14'd50);
    send_value(14'd400);
    send_value(14'd900);
    send_value(14'd500);
    send_value(14'd1000);
    send_value(14'd1994);
    send_value(14'd444);
    send_value(14'd999);
    send_value(14'd2000);
    send_value(14'd110);
    wait_for_drain();
  endtask

  // Random numbers: mostly convertible ones, with boundary values, zeros and
  // numbers out of range mixed in. Full-width draws toggle every input bit.
  task automatic test_random_numbers(input int unsigned count);
    int unsigned pick;
    logic [ValueW-1:0] value;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        value = ValueW'($urandom_range(1, MaxValue));
      end else if (pick < 75) begin
        value = ValueW'($urandom_range(MaxValue - 12, MaxValue + 12));
      end else if (pick < 80) begin
        value = ValueW'($urandom_range(1, 20));
      end else if (pick < 90) begin
        value = ValueW'($urandom_range(MaxValue + 1, 16383));
      end else if (pick < 94) begin
        value = '0;
      end else begin
        value = ValueW'($urandom_range(0, 16383));
      end
      send_value(value);
    end
    wait_for_drain();
  endtask

  // Closing part with no idling at all: long numerals, then random numbers, back to back.
  task automatic test_back_to_back(input int unsigned count);
    idle_off = 1'b1;
    send_value(14'd2888);
    send_value(14'd2888);
    send_value(14'd0);
    send_value(14'd3001);
    for (int unsigned n = 0; n < count; n++) begin
      send_value(ValueW'($urandom_range(0, 3100)));
    end
    wait_for_drain();
  endtask

  initial begin : run_tests
    rst_ni      = 1'b0;
    push        = 1'b0;
    value_i     = '0;
    error_count = 0;
    idle_off    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_boundaries();
    test_digit_patterns();
    test_random_numbers(420);
    test_back_to_back(40);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // A correct run ends far sooner; this only catches a hung handshake.
  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
